// File: src/gha_pkg.sv
// Package for the generational handle allocator.
// Holds the sizes, operation and status codes, sequencer states and payload structs.
// No dependencies.
`default_nettype none

package gha_pkg;

  // Sizes of the slot pool and of one generation counter.
  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned GEN_BITS  = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

  // Operation codes carried by a request.
  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_QUERY   = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4
  } gha_op_e;

  // Status codes carried by a response.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } gha_status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_GEN,
    S_EXEC
  } gha_state_e;

  // One request transaction.
  typedef struct packed {
    logic [2:0]          operation;
    logic [IDX_W-1:0]    entity_index;
    logic [GEN_BITS-1:0] entity_generation;
  } gha_req_t;

  // One response transaction.
  typedef struct packed {
    logic [IDX_W-1:0]    result_index;
    logic [GEN_BITS-1:0] result_generation;
    logic                is_alive;
    logic [1:0]          status;
    logic [CNT_W-1:0]    alive_count;
  } gha_rsp_t;

endpackage

`default_nettype wire

// File: src/generational_handle_allocator.sv
// Top level of the generational handle allocator: sequencer, tables and result register.
// Depends on gha_pkg for sizes, codes and the request and response structs.
//
// Usage: a request transaction (create, destroy, alive query, generation read
// or clear) is taken at a rising edge where start is high and busy is low.
// The block then runs a three-step sequence: it reads the free stack top, reads
// the generation table (at the popped slot for a create, else at the request
// index), then updates both tables and the counters in the execute step.
// The response appears on rsp_o for exactly one cycle with done_o high.
// busy is low again in that same cycle. A new request is not accepted until
// the previous one has been answered, because the two dependent reads of the
// single-port tables must come before the write.
// The receiver cannot stall: each response is taken in the cycle it is shown.
// Reset clears the sequencer, the stack depth, the high-water mark and the
// live count; table contents are not cleared and only entries that have been
// written are ever used. A clear request empties the pool in one pass.
`default_nettype none

module generational_handle_allocator (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire gha_pkg::gha_req_t req_i,
  output logic                   done_o,
  output gha_pkg::gha_rsp_t      rsp_o
);

  localparam int unsigned IdxW = gha_pkg::IDX_W;
  localparam int unsigned GenW = gha_pkg::GEN_BITS;
  localparam int unsigned CntW = gha_pkg::CNT_W;
  localparam logic [CntW-1:0] MaxSlots = CntW'(gha_pkg::MAX_SLOTS);

  // Sequencer and control registers.
  gha_pkg::gha_state_e state_q, state_d;
  gha_pkg::gha_req_t   req_q;
  logic [CntW-1:0]     depth_q, depth_d;
  logic [CntW-1:0]     mark_q, mark_d;
  logic [CntW-1:0]     live_q, live_d;
  logic                done_q, done_d;
  gha_pkg::gha_rsp_t   rsp_q, rsp_d;

  // Table storage and registered read data.
  logic [GenW-1:0] gen_mem_q [gha_pkg::MAX_SLOTS];
  logic [IdxW-1:0] stack_mem_q [gha_pkg::MAX_SLOTS];
  logic [GenW-1:0] gen_rd_q;
  logic [IdxW-1:0] stack_rd_q;

  // Table access controls.
  logic            gen_re, gen_we, stack_re, stack_we;
  logic [IdxW-1:0] gen_ra, gen_wa, stack_ra, stack_wa;
  logic [GenW-1:0] gen_wd;

  // Shared compare and increment unit used by the execute step.
  logic            in_range;
  logic            is_null;
  logic            gen_match;
  logic            handle_live;
  logic [GenW-1:0] gen_next;

  assign in_range    = {1'b0, req_q.entity_index} < mark_q;
  assign is_null     = (req_q.entity_index == '0) && (req_q.entity_generation == '0);
  assign gen_match   = gen_rd_q == req_q.entity_generation;
  assign handle_live = !is_null && in_range && gen_match;
  assign gen_next    = gen_rd_q + GenW'(1);

  // Generation table: one read or one write per cycle.
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem_q[gen_wa] <= gen_wd;
    end
    if (gen_re) begin
      gen_rd_q <= gen_mem_q[gen_ra];
    end
  end

  // Free stack: one read or one write per cycle.
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem_q[stack_wa] <= req_q.entity_index;
    end
    if (stack_re) begin
      stack_rd_q <= stack_mem_q[stack_ra];
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gha_pkg::S_IDLE;
      depth_q <= '0;
      mark_q  <= '0;
      live_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      mark_q  <= mark_d;
      live_q  <= live_d;
      done_q  <= done_d;
    end
  end

  // Next state, table accesses and the execute step.
  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    mark_d   = mark_q;
    live_d   = live_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    gen_re   = 1'b0;
    gen_ra   = req_q.entity_index;
    gen_we   = 1'b0;
    gen_wa   = req_q.entity_index;
    gen_wd   = gen_next;
    stack_re = 1'b0;
    stack_ra = IdxW'(depth_q - CntW'(1));
    stack_we = 1'b0;
    stack_wa = depth_q[IdxW-1:0];

    case (state_q)
      gha_pkg::S_IDLE: begin
        if (start) begin
          state_d = gha_pkg::S_FETCH;
        end
      end

      // Read the top of the free stack.
      gha_pkg::S_FETCH: begin
        stack_re = 1'b1;
        state_d  = gha_pkg::S_GEN;
      end

      // Read the generation of the popped slot or of the requested slot.
      gha_pkg::S_GEN: begin
        gen_re = 1'b1;
        if (req_q.operation == gha_pkg::OP_CREATE) begin
          gen_ra = stack_rd_q;
        end
        state_d = gha_pkg::S_EXEC;
      end

      // Update tables and counters and register the response.
      gha_pkg::S_EXEC: begin
        state_d = gha_pkg::S_IDLE;
        done_d  = 1'b1;
        rsp_d   = '0;
        case (req_q.operation)
          gha_pkg::OP_CREATE: begin
            if (depth_q != '0) begin
              depth_d                 = depth_q - CntW'(1);
              live_d                  = live_q + CntW'(1);
              rsp_d.result_index      = stack_rd_q;
              rsp_d.result_generation = gen_rd_q;
            end else if (mark_q != MaxSlots) begin
              gen_we                  = 1'b1;
              gen_wa                  = mark_q[IdxW-1:0];
              gen_wd                  = GenW'(1);
              mark_d                  = mark_q + CntW'(1);
              live_d                  = live_q + CntW'(1);
              rsp_d.result_index      = mark_q[IdxW-1:0];
              rsp_d.result_generation = GenW'(1);
            end else begin
              rsp_d.status = gha_pkg::ST_FULL;
            end
          end
          gha_pkg::OP_DESTROY: begin
            if (handle_live && (depth_q != MaxSlots)) begin
              gen_we   = 1'b1;
              stack_we = 1'b1;
              depth_d  = depth_q + CntW'(1);
              if (live_q != '0) begin
                live_d = live_q - CntW'(1);
              end
            end else begin
              rsp_d.status = gha_pkg::ST_IGNORED;
            end
          end
          gha_pkg::OP_QUERY: begin
            rsp_d.is_alive = handle_live;
          end
          gha_pkg::OP_READ: begin
            if (in_range) begin
              rsp_d.result_generation = gen_rd_q;
            end
          end
          gha_pkg::OP_CLEAR: begin
            depth_d = '0;
            mark_d  = '0;
            live_d  = '0;
          end
          default: begin
            rsp_d.status = gha_pkg::ST_IGNORED;
          end
        endcase
        rsp_d.alive_count = live_d;
      end

      default: begin
        state_d = gha_pkg::S_IDLE;
      end
    endcase
  end

  assign busy   = state_q != gha_pkg::S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A response is shown only right after an execute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == gha_pkg::S_EXEC))
    else $error("response strobe without an execute step");

  // An accepted request always starts the sequence at the stack fetch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == gha_pkg::S_FETCH))
    else $error("accepted request did not start the sequence");

  // Stack depth and high-water mark never pass the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q <= MaxSlots) && (mark_q <= MaxSlots))
    else $error("stack depth or high-water mark out of range");

  // A failed create reports the null handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == gha_pkg::ST_FULL)) |->
      ((rsp_o.result_index == '0) && (rsp_o.result_generation == '0)))
    else $error("failed create returned a handle");

  // A live answer only comes with a done status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.is_alive) |-> (rsp_o.status == gha_pkg::ST_DONE))
    else $error("live answer with a non-done status");

endmodule

`default_nettype wire
